// ===== design/halo_page_fetch_planner_top_defines.svh =====
// Assertion macros for the halo page fetch planner checker.
`ifndef HALO_PAGE_FETCH_PLANNER_TOP_DEFINES_SVH
`define HALO_PAGE_FETCH_PLANNER_TOP_DEFINES_SVH

// same-cycle implication
`define HPFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HPFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hpfp_pkg.sv =====
package hpfp_pkg;

  localparam int unsigned FE_W       = 16;
  localparam int unsigned SZ_W       = 32;
  localparam int unsigned VIS_W      = 48;
  localparam int unsigned PAGE_W     = 32;
  localparam int unsigned SRC_SPLIT  = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned IN_TDATA_W = 32;
  localparam int unsigned OUT_TDATA_W = 184;
  localparam int unsigned OUT_USED_W  = 1 + VIS_W + 4 * SZ_W;
  localparam int unsigned DIV_STEPS  = VIS_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_ELEMENTS = 3'd0,
    CFG_FRAME_PAGE_BYTES = 3'd1,
    CFG_PAYLOAD_BYTES = 3'd2,
    CFG_HALO_PREFIX_BYTES = 3'd3,
    CFG_VISIBLE_BYTES = 3'd4,
    CFG_SCAN_MODE = 3'd5
  } cfg_idx_t;

  // derived configuration, stable while idle is set
  typedef struct packed {
    logic             idle;
    logic             bad;
    logic             scan;
    logic [SZ_W-1:0]  fpb;
    logic [SZ_W-1:0]  eb;
    logic [FE_W-1:0]  pay_el;
    logic [FE_W-1:0]  pre_el;
    logic [FE_W-1:0]  room_el;
    logic [VIS_W-1:0] act_el;
  } cfg_derived_t;

endpackage

// ===== design/hpfp_cfg_unit.sv =====
module hpfp_cfg_unit
  import hpfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_derived_t          cfg_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_EB,
    ST_DIV_PAY,
    ST_DIV_PRE,
    ST_DIV_ACT,
    ST_CHECK
  } state_t;

  state_t               state_r;
  logic [FE_W-1:0]      fe_r;
  logic [SZ_W-1:0]      fpb_r;
  logic [SZ_W-1:0]      pay_r;
  logic [SZ_W-1:0]      pre_r;
  logic [VIS_W-1:0]     vis_r;
  logic                 scan_r;
  logic                 bad_r;
  logic [SZ_W-1:0]      eb_r;
  logic [SZ_W-1:0]      payq_r;
  logic [SZ_W-1:0]      preq_r;
  logic [VIS_W-1:0]     act_r;

  // shared restoring divider, one quotient bit per cycle until a configuration write restarts it
  logic [VIS_W-1:0]     num_r;
  logic [SZ_W-1:0]      den_r;
  logic [SZ_W-1:0]      rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  logic [SZ_W:0]        rem_sh;
  logic [SZ_W:0]        sub;
  logic                 ge;
  logic [SZ_W-1:0]      rem_n;
  logic [VIS_W-1:0]     num_n;
  logic                 last;
  logic [SZ_W:0]        room_chk;

  assign rem_sh   = {rem_r, num_r[VIS_W-1]};
  assign sub      = rem_sh - {1'b0, den_r};
  assign ge       = ~sub[SZ_W];
  assign rem_n    = ge ? sub[SZ_W-1:0] : rem_sh[SZ_W-1:0];
  assign num_n    = {num_r[VIS_W-2:0], ge};
  assign last     = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign room_chk = {{(SZ_W+1-FE_W){1'b0}}, fe_r} - {1'b0, preq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fe_r    <= FE_W'(1);
      fpb_r   <= '0;
      pay_r   <= '0;
      pre_r   <= '0;
      vis_r   <= '0;
      scan_r  <= 1'b0;
      bad_r   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_ELEMENTS:    fe_r   <= cfg_data[FE_W-1:0];
        CFG_FRAME_PAGE_BYTES:  fpb_r  <= cfg_data[SZ_W-1:0];
        CFG_PAYLOAD_BYTES:     pay_r  <= cfg_data[SZ_W-1:0];
        CFG_HALO_PREFIX_BYTES: pre_r  <= cfg_data[SZ_W-1:0];
        CFG_VISIBLE_BYTES:     vis_r  <= cfg_data[VIS_W-1:0];
        CFG_SCAN_MODE:         scan_r <= cfg_data[0];
        default: ;
      endcase
      state_r <= ST_START;
    end else begin
      case (state_r)
        ST_IDLE: ;
        ST_START: begin
          if (fe_r == '0 || fpb_r == '0 || pay_r == '0) begin
            bad_r   <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            num_r   <= VIS_W'(fpb_r);
            den_r   <= SZ_W'(fe_r);
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV_EB;
          end
        end
        ST_DIV_EB, ST_DIV_PAY, ST_DIV_PRE, ST_DIV_ACT: begin
          if (!last) begin
            num_r <= num_n;
            rem_r <= rem_n;
            cnt_r <= cnt_r + 1'b1;
          end else begin
            rem_r <= '0;
            cnt_r <= '0;
            case (state_r)
              ST_DIV_EB: begin
                if (rem_n != '0) begin
                  bad_r   <= 1'b1;
                  state_r <= ST_IDLE;
                end else begin
                  eb_r    <= num_n[SZ_W-1:0];
                  den_r   <= num_n[SZ_W-1:0];
                  num_r   <= VIS_W'(pay_r);
                  state_r <= ST_DIV_PAY;
                end
              end
              ST_DIV_PAY: begin
                payq_r  <= num_n[SZ_W-1:0];
                num_r   <= VIS_W'(pre_r);
                state_r <= ST_DIV_PRE;
              end
              ST_DIV_PRE: begin
                preq_r  <= num_n[SZ_W-1:0];
                num_r   <= vis_r;
                state_r <= ST_DIV_ACT;
              end
              default: begin
                act_r   <= num_n;
                state_r <= ST_CHECK;
              end
            endcase
          end
        end
        ST_CHECK: begin
          bad_r   <= (payq_r == '0) || (preq_r > SZ_W'(fe_r)) ||
                     ({1'b0, payq_r} > room_chk);
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ready     = 1'b1;
  assign cfg_o.idle    = (state_r == ST_IDLE);
  assign cfg_o.bad     = bad_r;
  assign cfg_o.scan    = scan_r;
  assign cfg_o.fpb     = fpb_r;
  assign cfg_o.eb      = eb_r;
  assign cfg_o.pay_el  = payq_r[FE_W-1:0];
  assign cfg_o.pre_el  = preq_r[FE_W-1:0];
  assign cfg_o.room_el = fe_r - preq_r[FE_W-1:0];
  assign cfg_o.act_el  = act_r;

endmodule

// ===== design/halo_page_fetch_planner_top.sv =====
// Halo page fetch planner. One page index beat in, one plan beat out, in order.
// The datapath is a six-stage pipeline (payload-element multiply, window bounds,
// clipping, byte-scale multiplies, partial-product sum, final checks) that takes
// one beat per cycle unless out_tready or a divider run holds it. Element size
// and element counts come from a shared radix-2 divider that runs after every
// configuration write; in_tready stays low through its setup state, four
// divisions with 48-bit quotients and check state, ending early on a bad field.
// After reset the block is ready at once and rejects every page until it is
// configured. Rejected plans carry ok=0 and all fields zero.
module halo_page_fetch_planner_top
  import hpfp_pkg::*;
#(
  parameter int unsigned OFFSET_WIDTH = 48,
  parameter int unsigned SIZE_WIDTH   = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] page_index
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] ok, [48:1] src_offset, [80:49] frame_offset, [112:81] transfer_length,
  // [144:113] leading_fill, [176:145] trailing_fill_start, [183:177] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_derived_t cfg;

  hpfp_cfg_unit u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  localparam int unsigned PROD_W = SRC_SPLIT + SZ_W;
  localparam int unsigned SC_W   = FE_W + SZ_W;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

  assign rdy_out   = ~out_v_r | out_tready;
  assign rdy5      = ~v5_r | rdy_out;
  assign rdy4      = ~v4_r | rdy5;
  assign rdy3      = ~v3_r | rdy4;
  assign rdy2      = ~v2_r | rdy3;
  assign rdy1      = ~v1_r | rdy2;
  assign in_tready = rdy1 & cfg.idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r    <= in_tvalid & cfg.idle;
      if (rdy2)    v2_r    <= v1_r;
      if (rdy3)    v3_r    <= v2_r;
      if (rdy4)    v4_r    <= v3_r;
      if (rdy5)    v5_r    <= v4_r;
      if (rdy_out) out_v_r <= v5_r;
    end
  end

  // stage 1: first payload element
  logic [VIS_W-1:0] s1_cf_r;

  always_ff @(posedge clk) begin
    if (rdy1) s1_cf_r <= in_tdata[PAGE_W-1:0] * cfg.pay_el;
  end

  // stage 2: window start and raw end
  logic [VIS_W-1:0] pre48;
  logic [VIS_W-1:0] first_h;
  logic [FE_W-1:0]  tgt_h;
  logic [VIS_W-1:0] s2_first_r;
  logic [FE_W-1:0]  s2_tgt_r;
  logic [VIS_W-1:0] s2_xscan_r;
  logic [VIS_W:0]   s2_end_r;
  logic             s2_rej_r;

  assign pre48   = VIS_W'(cfg.pre_el);
  assign first_h = (s1_cf_r > pre48) ? s1_cf_r - pre48 : '0;
  assign tgt_h   = (s1_cf_r >= pre48) ? '0 : FE_W'(pre48 - s1_cf_r);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_first_r <= cfg.scan ? s1_cf_r : first_h;
      s2_tgt_r   <= cfg.scan ? cfg.pre_el : tgt_h;
      s2_xscan_r <= cfg.act_el - s1_cf_r;
      s2_end_r   <= {1'b0, s1_cf_r} + (VIS_W+1)'(cfg.room_el);
      s2_rej_r   <= (s1_cf_r >= cfg.act_el);
    end
  end

  // stage 3: clip to visible data
  logic [VIS_W-1:0] end_el;
  logic             empty;
  logic [FE_W-1:0]  xfer_h;
  logic [FE_W-1:0]  xfer_s;
  logic [VIS_W-1:0] s3_first_r;
  logic [FE_W-1:0]  s3_tgt_r;
  logic [FE_W-1:0]  s3_xfer_r;
  logic             s3_rej_r;

  assign end_el = (s2_end_r < {1'b0, cfg.act_el}) ? s2_end_r[VIS_W-1:0] : cfg.act_el;
  assign empty  = (end_el <= s2_first_r);
  assign xfer_h = FE_W'(end_el - s2_first_r);
  assign xfer_s = (s2_xscan_r < VIS_W'(cfg.pay_el)) ? s2_xscan_r[FE_W-1:0] : cfg.pay_el;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_first_r <= s2_first_r;
      s3_tgt_r   <= s2_tgt_r;
      s3_xfer_r  <= cfg.scan ? xfer_s : xfer_h;
      s3_rej_r   <= s2_rej_r | (~cfg.scan & empty);
    end
  end

  // stage 4: scale to bytes, source split in two partial products
  logic [PROD_W-1:0] s4_hi_r;
  logic [PROD_W-1:0] s4_lo_r;
  logic [SC_W-1:0]   s4_tgt_r;
  logic [SC_W-1:0]   s4_xfer_r;
  logic              s4_rej_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_hi_r   <= s3_first_r[VIS_W-1:SRC_SPLIT] * cfg.eb;
      s4_lo_r   <= s3_first_r[SRC_SPLIT-1:0] * cfg.eb;
      s4_tgt_r  <= s3_tgt_r * cfg.eb;
      s4_xfer_r <= s3_xfer_r * cfg.eb;
      s4_rej_r  <= s3_rej_r;
    end
  end

  // stage 5: sums
  logic [PROD_W+SRC_SPLIT-1:0] src_full;
  logic [VIS_W-1:0]            s5_src_r;
  logic [SC_W-1:0]             s5_tgt_r;
  logic [SC_W-1:0]             s5_xfer_r;
  logic [SC_W:0]               s5_trail_r;
  logic                        s5_rej_r;

  assign src_full = {s4_hi_r, {SRC_SPLIT{1'b0}}} + (PROD_W+SRC_SPLIT)'(s4_lo_r);

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_src_r   <= src_full[VIS_W-1:0];
      s5_tgt_r   <= s4_tgt_r;
      s5_xfer_r  <= s4_xfer_r;
      s5_trail_r <= {1'b0, s4_tgt_r} + {1'b0, s4_xfer_r};
      s5_rej_r   <= s4_rej_r;
    end
  end

  // stage 6: overrun and width checks, output register
  logic                   overrun;
  logic                   wide_src;
  logic                   wide_size;
  logic                   rej;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign overrun   = (s5_trail_r > (SC_W+1)'(cfg.fpb));
  assign wide_src  = ((s5_src_r >> OFFSET_WIDTH) != '0);
  assign wide_size = ((s5_tgt_r >> SIZE_WIDTH) != '0) ||
                     ((s5_xfer_r >> SIZE_WIDTH) != '0) ||
                     ((s5_trail_r >> SIZE_WIDTH) != '0);
  assign rej       = s5_rej_r | cfg.bad | overrun | wide_src | wide_size;

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      if (rej) begin
        out_tdata_r <= '0;
      end else begin
        out_tdata_r <= {{(OUT_TDATA_W-OUT_USED_W){1'b0}},
                        s5_trail_r[SZ_W-1:0], s5_tgt_r[SZ_W-1:0],
                        s5_xfer_r[SZ_W-1:0], s5_tgt_r[SZ_W-1:0],
                        s5_src_r, 1'b1};
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== design/hpfp_checker.sv =====
`include "halo_page_fetch_planner_top_defines.svh"

module hpfp_checker
  import hpfp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  logic [SZ_W:0] trail_sum;

  assign trail_sum = {1'b0, out_tdata[80:49]} + {1'b0, out_tdata[112:81]};

  `HPFP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output beat changed while stalled")
  `HPFP_ASSERT_IMP(a_reject_zero, out_tvalid && !out_tdata[0], out_tdata[OUT_TDATA_W-1:1] == '0, "rejected plan has nonzero fields")
  `HPFP_ASSERT_IMP(a_lead_eq_frame, out_tvalid, out_tdata[144:113] == out_tdata[80:49], "leading fill differs from frame offset")
  `HPFP_ASSERT_IMP(a_trail_sum, out_tvalid && out_tdata[0], trail_sum == {1'b0, out_tdata[176:145]}, "trailing fill start is not frame offset plus length")
  `HPFP_ASSERT_NXT(a_cfg_holds_input, cfg_valid && cfg_ready, !in_tready, "input taken right after a configuration write")

endmodule

bind halo_page_fetch_planner_top hpfp_checker u_hpfp_checker (.*);
